// File: hw/rtl/ccsp_pkg.sv
// shared widths and the packet type for the circle column point generator
// no dependencies; imported by every module of the block
package ccsp_pkg;

    localparam int RADIUS_BITS   = 10;
    localparam int CENTER_BITS   = 11;
    localparam int COORD_BITS    = 12;
    localparam int RADICAND_BITS = 2 * RADIUS_BITS;
    localparam int REM_BITS      = RADIUS_BITS + 1;
    localparam int Y_BITS        = RADIUS_BITS + 1;
    localparam int POINTS        = 8;
    localparam int PT_IDX_BITS   = $clog2(POINTS);
    localparam int S_DATA_BITS   = ((2 * CENTER_BITS + 2 * RADIUS_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS   = ((2 * COORD_BITS + 7) / 8) * 8;

    // one item on its way through the square root row
    typedef struct packed {
        logic signed [CENTER_BITS-1:0] cx;
        logic signed [CENTER_BITS-1:0] cy;
        logic [RADIUS_BITS-1:0]        col;
        logic [RADICAND_BITS-1:0]      radicand;
        logic [REM_BITS-1:0]           rem;
        logic [RADIUS_BITS-1:0]        root;
    } root_pkt_t;

endpackage

// File: hw/rtl/ccsp_front.sv
// front end: squares radius and column, then forms the saturated radicand
// depends on ccsp_pkg; feeds the first square root cell
module ccsp_front
    import ccsp_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [CENTER_BITS-1:0] cx,
    input  logic signed [CENTER_BITS-1:0] cy,
    input  logic [RADIUS_BITS-1:0]        radius,
    input  logic [RADIUS_BITS-1:0]        column,
    output logic                          out_valid,
    input  logic                          out_ready,
    output root_pkt_t                     out_pkt
);

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic signed [CENTER_BITS-1:0] s1_cx_reg;
    logic signed [CENTER_BITS-1:0] s1_cy_reg;
    logic [RADIUS_BITS-1:0]        s1_col_reg;
    logic [RADICAND_BITS-1:0]      s1_rr_reg;
    logic [RADICAND_BITS-1:0]      s1_xx_reg;
    logic                          s1_ready;

    logic                          s2_valid_reg;
    logic                          s2_valid_next;
    root_pkt_t                     s2_pkt_reg;
    root_pkt_t                     s2_pkt_next;
    logic                          s2_ready;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    assign s1_valid_next = s1_ready ? in_valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    always_comb
    begin
        s2_pkt_next          = '0;
        s2_pkt_next.cx       = s1_cx_reg;
        s2_pkt_next.cy       = s1_cy_reg;
        s2_pkt_next.col      = s1_col_reg;
        // column beyond radius saturates the radicand to zero
        s2_pkt_next.radicand = (s1_xx_reg > s1_rr_reg) ? '0 : s1_rr_reg - s1_xx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_cx_reg  <= cx;
            s1_cy_reg  <= cy;
            s1_col_reg <= column;
            s1_rr_reg  <= RADICAND_BITS'(radius) * RADICAND_BITS'(radius);
            s1_xx_reg  <= RADICAND_BITS'(column) * RADICAND_BITS'(column);
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_pkt_reg <= s2_pkt_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_pkt   = s2_pkt_reg;

endmodule

// File: hw/rtl/ccsp_root_cell.sv
// one cell of the square root row: resolves one root bit per item
// depends on ccsp_pkg; chained RADIUS_BITS times in the top level
module ccsp_root_cell
    import ccsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  root_pkt_t in_pkt,
    output logic      out_valid,
    input  logic      out_ready,
    output root_pkt_t out_pkt
);

    logic                  valid_reg;
    logic                  valid_next;
    root_pkt_t             pkt_reg;
    root_pkt_t             pkt_next;
    logic [REM_BITS+1:0]   rem_shift;
    logic [REM_BITS+1:0]   trial;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb
    begin
        // bring down the next two radicand bits and try root*4+1
        rem_shift         = {in_pkt.rem, in_pkt.radicand[RADICAND_BITS-1 -: 2]};
        trial             = (REM_BITS+2)'({in_pkt.root, 2'b01});
        pkt_next          = in_pkt;
        pkt_next.radicand = {in_pkt.radicand[RADICAND_BITS-3:0], 2'b00};
        if (rem_shift >= trial)
        begin
            pkt_next.rem  = REM_BITS'(rem_shift - trial);
            pkt_next.root = {in_pkt.root[RADIUS_BITS-2:0], 1'b1};
        end
        else
        begin
            pkt_next.rem  = REM_BITS'(rem_shift);
            pkt_next.root = {in_pkt.root[RADIUS_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pkt_reg <= pkt_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pkt   = pkt_reg;

endmodule

// File: hw/rtl/ccsp_emit.sv
// output stage: rounds the root and sends the eight symmetric points
// depends on ccsp_pkg; takes packets from the last square root cell
module ccsp_emit
    import ccsp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  root_pkt_t             in_pkt,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_BITS-1:0] m_tdata,
    output logic                  m_tlast
);

    localparam logic [PT_IDX_BITS-1:0] LAST_PT = PT_IDX_BITS'(POINTS - 1);

    logic                          busy_reg;
    logic                          busy_next;
    logic [PT_IDX_BITS-1:0]        idx_reg;
    logic [PT_IDX_BITS-1:0]        idx_next;
    logic signed [CENTER_BITS-1:0] cx_reg;
    logic signed [CENTER_BITS-1:0] cy_reg;
    logic [RADIUS_BITS-1:0]        col_reg;
    logic [Y_BITS-1:0]             y_reg;
    logic [Y_BITS-1:0]             y_next;
    logic                          load;
    logic                          swap;
    logic                          neg_h;
    logic                          neg_v;
    logic [COORD_BITS-1:0]         base_x;
    logic [COORD_BITS-1:0]         base_y;
    logic [COORD_BITS-1:0]         term_x;
    logic [COORD_BITS-1:0]         term_y;
    logic [COORD_BITS-1:0]         point_x;
    logic [COORD_BITS-1:0]         point_y;

    assign in_ready = !busy_reg || (m_tready && idx_reg == LAST_PT);
    assign load     = in_ready;

    // nearest integer: round up when the remainder exceeds the root
    assign y_next = Y_BITS'(in_pkt.root) + Y_BITS'(in_pkt.rem > REM_BITS'(in_pkt.root));

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = in_valid;
            idx_next  = '0;
        end
        else if (busy_reg && m_tready)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            cx_reg  <= in_pkt.cx;
            cy_reg  <= in_pkt.cy;
            col_reg <= in_pkt.col;
            y_reg   <= y_next;
        end
    end

    // points 0-3 offset by (x, y), points 4-7 by (y, x); odd points negate the
    // horizontal term, the vertical term is negated on points 1, 2, 6 and 7
    assign swap  = idx_reg[2];
    assign neg_h = idx_reg[0];
    assign neg_v = idx_reg[2] ? idx_reg[1] : (idx_reg[1] ^ idx_reg[0]);

    always_comb
    begin
        base_x = COORD_BITS'(cx_reg);
        base_y = COORD_BITS'(cy_reg);
        if (swap)
        begin
            term_x = COORD_BITS'(y_reg);
            term_y = COORD_BITS'(col_reg);
        end
        else
        begin
            term_x = COORD_BITS'(col_reg);
            term_y = COORD_BITS'(y_reg);
        end
        point_x = neg_h ? base_x - term_x : base_x + term_x;
        point_y = neg_v ? base_y - term_y : base_y + term_y;
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = M_DATA_BITS'({point_y, point_x});
    assign m_tlast  = (idx_reg == LAST_PT);

endmodule

// File: hw/rtl/circle_column_symmetric_points.sv
// circle column point generator: y = round(sqrt(r*r - x*x)), eight symmetric points
// a request passes the front end, the root cells and the output stage; its eight points
// then go out one per cycle while m_tready is high, all on the single point output port
// the square root row is fully pipelined, one root bit per cell
// reset (rst_n, async low) clears the valid flags and point counter; data is not reset
module circle_column_symmetric_points
    import ccsp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_DATA_BITS-1:0] s_tdata,   // center_x, center_y, radius, column, zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_DATA_BITS-1:0] m_tdata,   // point_x, point_y
    output logic                   m_tlast    // last_point
);

    localparam int CY_LO  = CENTER_BITS;
    localparam int RAD_LO = 2 * CENTER_BITS;
    localparam int COL_LO = 2 * CENTER_BITS + RADIUS_BITS;

    logic signed [CENTER_BITS-1:0] center_x;
    logic signed [CENTER_BITS-1:0] center_y;
    logic [RADIUS_BITS-1:0]        radius;
    logic [RADIUS_BITS-1:0]        column;

    root_pkt_t              pkt [0:RADIUS_BITS];
    logic [RADIUS_BITS:0]   vld;
    logic [RADIUS_BITS:0]   rdy;

    assign center_x = s_tdata[CENTER_BITS-1:0];
    assign center_y = s_tdata[CY_LO +: CENTER_BITS];
    assign radius   = s_tdata[RAD_LO +: RADIUS_BITS];
    assign column   = s_tdata[COL_LO +: RADIUS_BITS];

    ccsp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .cx        (center_x),
        .cy        (center_y),
        .radius    (radius),
        .column    (column),
        .out_valid (vld[0]),
        .out_ready (rdy[0]),
        .out_pkt   (pkt[0])
    );

    for (genvar i = 0; i < RADIUS_BITS; i++)
    begin : g_cell
        ccsp_root_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld[i]),
            .in_ready  (rdy[i]),
            .in_pkt    (pkt[i]),
            .out_valid (vld[i+1]),
            .out_ready (rdy[i+1]),
            .out_pkt   (pkt[i+1])
        );
    end

    ccsp_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vld[RADIUS_BITS]),
        .in_ready (rdy[RADIUS_BITS]),
        .in_pkt   (pkt[RADIUS_BITS]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // a request is not dropped before its eighth point goes out
    a_hold_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("point stream ended before last point");

    // the output only comes up with a packet from the last root cell
    a_rise_from_row: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(vld[RADIUS_BITS]))
        else $error("output became valid with no packet from the root row");

    // after the last point with nothing waiting, the output goes idle
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast && !vld[RADIUS_BITS] |=> !m_tvalid)
        else $error("output stayed valid with no pending request");
`endif

endmodule
